// ===== src/spc_pkg.sv =====
// Shared types, constants and the sine table of the plasma cell generator.
package spc_pkg;

  // Frame phases, kept together as one word of the phase memory.
  typedef struct packed {
    logic [7:0] col_a;
    logic [7:0] col_b;
    logic [7:0] row_a;
    logic [7:0] row_b;
  } phase_t;

  // The four sine terms of one cell.
  typedef struct packed {
    logic [7:0] row_a;
    logic [7:0] row_b;
    logic [7:0] col_a;
    logic [7:0] col_b;
  } sine_t;

  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_CELL    = 1'b1;

  // Spatial frequencies.
  localparam logic [7:0] ROW_A_MUL = 8'd4;
  localparam logic [7:0] ROW_B_MUL = 8'd9;
  localparam logic [7:0] COL_A_MUL = 8'd3;
  localparam logic [7:0] COL_B_MUL = 8'd7;

  // Per-frame phase steps; the b phases run backward.
  localparam logic [7:0] COL_A_STEP = 8'd2;
  localparam logic [7:0] COL_B_STEP = 8'd3;
  localparam logic [7:0] ROW_A_STEP = 8'd3;
  localparam logic [7:0] ROW_B_STEP = 8'd5;

  localparam logic [7:0] SINE_ROM [256] = '{
    8'h80, 8'h7d, 8'h7a, 8'h77, 8'h74, 8'h70, 8'h6d, 8'h6a, 8'h67, 8'h64, 8'h61, 8'h5e,
    8'h5b, 8'h58, 8'h55, 8'h52, 8'h4f, 8'h4d, 8'h4a, 8'h47, 8'h44, 8'h41, 8'h3f, 8'h3c,
    8'h39, 8'h37, 8'h34, 8'h32, 8'h2f, 8'h2d, 8'h2b, 8'h28, 8'h26, 8'h24, 8'h22, 8'h20,
    8'h1e, 8'h1c, 8'h1a, 8'h18, 8'h16, 8'h15, 8'h13, 8'h11, 8'h10, 8'h0f, 8'h0d, 8'h0c,
    8'h0b, 8'h0a, 8'h08, 8'h07, 8'h06, 8'h06, 8'h05, 8'h04, 8'h03, 8'h03, 8'h02, 8'h02,
    8'h02, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h02, 8'h02, 8'h02, 8'h03,
    8'h03, 8'h04, 8'h05, 8'h06, 8'h06, 8'h07, 8'h08, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0f,
    8'h10, 8'h11, 8'h13, 8'h15, 8'h16, 8'h18, 8'h1a, 8'h1c, 8'h1e, 8'h20, 8'h22, 8'h24,
    8'h26, 8'h28, 8'h2b, 8'h2d, 8'h2f, 8'h32, 8'h34, 8'h37, 8'h39, 8'h3c, 8'h3f, 8'h41,
    8'h44, 8'h47, 8'h4a, 8'h4d, 8'h4f, 8'h52, 8'h55, 8'h58, 8'h5b, 8'h5e, 8'h61, 8'h64,
    8'h67, 8'h6a, 8'h6d, 8'h70, 8'h74, 8'h77, 8'h7a, 8'h7d, 8'h80, 8'h83, 8'h86, 8'h89,
    8'h8c, 8'h90, 8'h93, 8'h96, 8'h99, 8'h9c, 8'h9f, 8'ha2, 8'ha5, 8'ha8, 8'hab, 8'hae,
    8'hb1, 8'hb3, 8'hb6, 8'hb9, 8'hbc, 8'hbf, 8'hc1, 8'hc4, 8'hc7, 8'hc9, 8'hcc, 8'hce,
    8'hd1, 8'hd3, 8'hd5, 8'hd8, 8'hda, 8'hdc, 8'hde, 8'he0, 8'he2, 8'he4, 8'he6, 8'he8,
    8'hea, 8'heb, 8'hed, 8'hef, 8'hf0, 8'hf1, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf8, 8'hf9,
    8'hfa, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfd, 8'hfe, 8'hfe, 8'hfe, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hfe, 8'hfe, 8'hfe, 8'hfd, 8'hfd, 8'hfc, 8'hfb, 8'hfa,
    8'hfa, 8'hf9, 8'hf8, 8'hf6, 8'hf5, 8'hf4, 8'hf3, 8'hf1, 8'hf0, 8'hef, 8'hed, 8'heb,
    8'hea, 8'he8, 8'he6, 8'he4, 8'he2, 8'he0, 8'hde, 8'hdc, 8'hda, 8'hd8, 8'hd5, 8'hd3,
    8'hd1, 8'hce, 8'hcc, 8'hc9, 8'hc7, 8'hc4, 8'hc1, 8'hbf, 8'hbc, 8'hb9, 8'hb6, 8'hb3,
    8'hb1, 8'hae, 8'hab, 8'ha8, 8'ha5, 8'ha2, 8'h9f, 8'h9c, 8'h99, 8'h96, 8'h93, 8'h90,
    8'h8c, 8'h89, 8'h86, 8'h83
  };

endpackage

// ===== src/spc_sine_lookup.sv =====
// Table index generation and sine lookup for the four terms of one cell.
module spc_sine_lookup (
  input  spc_pkg::phase_t phase_i,
  input  logic [5:0]      row_i,
  input  logic [6:0]      col_i,
  output spc_pkg::sine_t  sine_o
);
  import spc_pkg::*;

  logic [7:0] idx_row_a;
  logic [7:0] idx_row_b;
  logic [7:0] idx_col_a;
  logic [7:0] idx_col_b;

  // Indices wrap at the table size.
  assign idx_row_a = phase_i.row_a + 8'(16'(row_i) * 16'(ROW_A_MUL));
  assign idx_row_b = phase_i.row_b + 8'(16'(row_i) * 16'(ROW_B_MUL));
  assign idx_col_a = phase_i.col_a + 8'(16'(col_i) * 16'(COL_A_MUL));
  assign idx_col_b = phase_i.col_b + 8'(16'(col_i) * 16'(COL_B_MUL));

  assign sine_o.row_a = SINE_ROM[idx_row_a];
  assign sine_o.row_b = SINE_ROM[idx_row_b];
  assign sine_o.col_a = SINE_ROM[idx_col_a];
  assign sine_o.col_b = SINE_ROM[idx_col_b];

endmodule

// ===== src/sine_plasma_cell_generator.sv =====
// Top level of the sine-table plasma cell generator.
//
// Input channel (in_valid_i / in_stall_o): one beat is a command. cmd_i = 1
// asks for the character code of the cell at row_i / col_i; cmd_i = 0 ends
// the frame and steps the four phases, giving no result beat.
// Output channel (out_valid_o / out_stall_i): one beat per cell request,
// cell_value_o, in request order.
// Throughput: one command per cycle while the output does not stall. A cell
// request passes the phase memory read and table lookup in one stage, the
// four-term sum in the next, then the output register.
// The four phases live as one word in a synchronous phase memory. Every
// accepted beat reads it; an advance writes the stepped word back when it
// reaches stage 1. A command accepted on the edge of that write takes the
// new phases from a bypass register instead of the stale read.
// Reset clears the pipeline valids and marks the phase memory as unwritten,
// so phases read as zero until the first advance; no clearing pass is run.
// A stall on the output holds the result; bubbles in front of it still
// fill, and the input stalls only once every stage holds a cell.
module sine_plasma_cell_generator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [5:0] row_i,
  input  logic [6:0] col_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] cell_value_o
);
  import spc_pkg::*;

  // Phase memory, a single word.
  phase_t phase_mem [1];
  logic   mem_ok_q;        // memory written at least once since reset

  // Stage 1: command plus phase read.
  logic       s1_vld_q, s1_vld_d;
  logic       s1_cmd_q;
  logic [5:0] s1_row_q;
  logic [6:0] s1_col_q;
  phase_t     rd_q;
  logic       rd_ok_q;
  logic       fwd_q;
  phase_t     wd_q;

  // Stage 2: sine terms.
  logic       s2_vld_q, s2_vld_d;
  sine_t      s2_sine_q;
  sine_t      sine_w;

  // Output register.
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_val_q;

  logic   out_free, s2_free, s1_free, acc, wr_en;
  phase_t ph_cur, ph_nxt;

  // Each stage moves when the one after it is empty or moving; an advance in stage 1 always leaves it.
  assign out_free = !out_vld_q || !out_stall_i;
  assign s2_free  = !s2_vld_q || out_free;
  assign s1_free  = !s1_vld_q || (s1_cmd_q == CMD_ADVANCE) || s2_free;
  assign acc      = in_valid_i && s1_free;
  assign wr_en    = s1_vld_q && (s1_cmd_q == CMD_ADVANCE);

  assign in_stall_o = !s1_free;

  // Bypass the write that landed with this beat's read.
  always_comb begin
    if (fwd_q) begin
      ph_cur = wd_q;
    end else if (rd_ok_q) begin
      ph_cur = rd_q;
    end else begin
      ph_cur = '0;
    end
  end

  always_comb begin
    ph_nxt.col_a = ph_cur.col_a + COL_A_STEP;
    ph_nxt.col_b = ph_cur.col_b - COL_B_STEP;
    ph_nxt.row_a = ph_cur.row_a + ROW_A_STEP;
    ph_nxt.row_b = ph_cur.row_b - ROW_B_STEP;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      phase_mem[0] <= ph_nxt;
    end
    if (acc) begin
      rd_q <= phase_mem[0];
    end
  end

  spc_sine_lookup u_lookup (
    .phase_i (ph_cur),
    .row_i   (s1_row_q),
    .col_i   (s1_col_q),
    .sine_o  (sine_w)
  );

  assign s1_vld_d  = s1_free ? acc : s1_vld_q;
  assign s2_vld_d  = s2_free ? (s1_vld_q && (s1_cmd_q == CMD_CELL)) : s2_vld_q;
  assign out_vld_d = out_free ? s2_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mem_ok_q  <= 1'b0;
      rd_ok_q   <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= out_vld_d;
      if (wr_en) begin
        mem_ok_q <= 1'b1;
      end
      if (acc) begin
        rd_ok_q <= mem_ok_q;
        fwd_q   <= wr_en;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_cmd_q <= cmd_i;
      s1_row_q <= row_i;
      s1_col_q <= col_i;
    end
    if (wr_en) begin
      wd_q <= ph_nxt;
    end
    if (s2_free && s1_vld_q && (s1_cmd_q == CMD_CELL)) begin
      s2_sine_q <= sine_w;
    end
    if (out_free && s2_vld_q) begin
      out_val_q <= s2_sine_q.row_a + s2_sine_q.row_b + s2_sine_q.col_a + s2_sine_q.col_b;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign cell_value_o = out_val_q;

endmodule

// ===== src/spc_checker.sv =====
// Port-level checks of the plasma cell generator, bound to its top level.
module spc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       cmd_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] cell_value_o
);
  import spc_pkg::*;

  logic cell_acc;
  assign cell_acc = in_valid_i && !in_stall_o && (cmd_i == CMD_CELL);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_value_o))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result present after reset");

  // With the output empty nothing backs up to the input.
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // No result appears without a cell request inside the pipeline depth.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cell_acc && !out_valid_o) ##1 (!cell_acc && !out_valid_o)
    ##1 (!cell_acc && !out_valid_o) |=> !out_valid_o)
    else $error("result without cell request");

endmodule

bind sine_plasma_cell_generator spc_checker u_spc_checker (.*);
